// ===== rtl/core/tscf_pkg.sv =====
// ----------------------------------------------------------------------------
// tscf_pkg
// Shared constants, register map and types of the text stream filter.
// ----------------------------------------------------------------------------
package tscf_pkg;

  // Default width of the line number in decimal digits
  localparam int unsigned NumberDigitsDefault = 6;
  // Entries in the queue between front and back
  localparam int unsigned QueueDepthDefault   = 2;

  // Configuration register indexes
  localparam int unsigned CfgAddrWidth = 5;
  localparam logic [2:0] REG_NUMBER_NONBLANK = 3'd0;
  localparam logic [2:0] REG_NUMBER_ALL      = 3'd1;
  localparam logic [2:0] REG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [2:0] REG_SHOW_ENDS       = 3'd3;
  localparam logic [2:0] REG_SHOW_TABS       = 3'd4;
  localparam logic [2:0] REG_SHOW_NONPRINT   = 3'd5;

  // Character codes
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NL      = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_DOLLAR  = 8'd36;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_QMARK   = 8'd63;
  localparam logic [7:0] CHAR_I       = 8'd73;
  localparam logic [7:0] CHAR_CARET   = 8'd94;
  localparam logic [7:0] CHAR_DEL     = 8'd127;
  localparam logic [7:0] CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  // Option bits
  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprint;
  } tscf_cfg_t;

  // Work for one input byte: optional number prefix, then up to three
  // suffix bytes ('$', carets, the byte itself)
  typedef struct packed {
    logic            numbered;
    logic [1:0]      sfx_last;
    logic [2:0][7:0] sfx;
  } tscf_desc_t;

endpackage

// ===== rtl/core/tscf_front.sv =====
// ----------------------------------------------------------------------------
// tscf_front
// Accepts input bytes, tracks line state and builds one work descriptor per
// byte that is not squeezed away.
// ----------------------------------------------------------------------------
module tscf_front import tscf_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = NumberDigitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tscf_cfg_t                  cfg_i,
  input  logic                       s_valid_i,
  input  logic [7:0]                 s_byte_i,
  output logic                       s_ready_o,
  input  logic                       q_full_i,
  output logic                       push_o,
  output tscf_desc_t                 desc_o,
  output logic [4*NUMBER_DIGITS-1:0] bcd_o
);

  localparam int unsigned BcdWidth = 4 * NUMBER_DIGITS;

  // Saturating BCD increment
  function automatic logic [BcdWidth-1:0] bcd_inc(input logic [BcdWidth-1:0] v);
    logic [BcdWidth-1:0] r;
    logic                carry;
    logic                nines;
    r     = v;
    carry = 1'b1;
    nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) nines = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] >= 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return nines ? v : r;
  endfunction

  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic                line_start_q, line_start_d;
  logic [1:0]          nl_run_q, nl_run_d;

  logic       accept;
  logic       is_nl;
  logic       caret;
  logic       drop;
  logic       c1, c2, c3, dollar;
  logic [7:0] b1, b2, b3;
  logic [1:0] cnt;
  logic       numbered;

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && !q_full_i;
  assign is_nl     = (s_byte_i == CHAR_NL);
  assign caret     = cfg_i.show_nonprint || cfg_i.show_ends || cfg_i.show_tabs;
  assign drop      = cfg_i.squeeze_blank && is_nl && (nl_run_q >= 2'd2);
  assign push_o    = accept && !drop;
  assign bcd_o     = bcd_q;

  // Classify the byte: caret escapes, tab display, end marker
  always_comb begin
    c1 = caret && (((s_byte_i < CTRL_LIMIT) && (s_byte_i != CHAR_TAB) && !is_nl)
                   || s_byte_i[7]);
    b1 = c1 ? (s_byte_i + CARET_OFFSET) : s_byte_i;
    c2 = caret && (b1 == CHAR_DEL);
    b2 = c2 ? CHAR_QMARK : b1;
    c3 = cfg_i.show_tabs && (b2 == CHAR_TAB);
    b3 = c3 ? CHAR_I : b2;
    dollar = cfg_i.show_ends && is_nl;
  end

  // Pack the suffix bytes in output order
  always_comb begin
    cnt    = 2'd0;
    desc_o = '0;
    if (dollar) begin
      desc_o.sfx[cnt] = CHAR_DOLLAR;
      cnt = cnt + 2'd1;
    end
    if (c1) begin
      desc_o.sfx[cnt] = CHAR_CARET;
      cnt = cnt + 2'd1;
    end
    if (c2 || c3) begin
      desc_o.sfx[cnt] = CHAR_CARET;
      cnt = cnt + 2'd1;
    end
    desc_o.sfx[cnt] = b3;
    desc_o.sfx_last = cnt;
    desc_o.numbered = numbered;
  end

  assign numbered = line_start_q &&
                    (cfg_i.number_nonblank ? !is_nl : cfg_i.number_all);

  // Advance line state on each byte that is kept
  always_comb begin
    bcd_d        = bcd_q;
    line_start_d = line_start_q;
    nl_run_d     = nl_run_q;
    if (push_o) begin
      nl_run_d     = (cfg_i.squeeze_blank && is_nl) ? nl_run_q + 2'd1 : 2'd0;
      line_start_d = is_nl;
      if (numbered) bcd_d = bcd_inc(bcd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q        <= BcdWidth'(1);
      line_start_q <= 1'b1;
      nl_run_q     <= 2'd1;
    end else begin
      bcd_q        <= bcd_d;
      line_start_q <= line_start_d;
      nl_run_q     <= nl_run_d;
    end
  end

endmodule

// ===== rtl/core/tscf_queue.sv =====
// ----------------------------------------------------------------------------
// tscf_queue
// Small FIFO of work descriptors between the front and the back.
// ----------------------------------------------------------------------------
module tscf_queue import tscf_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ===== rtl/core/tscf_back.sv =====
// ----------------------------------------------------------------------------
// tscf_back
// Walks each descriptor one output word per cycle while the output is ready:
// number digits, tab, then suffix bytes, into a registered output stage.
// ----------------------------------------------------------------------------
module tscf_back import tscf_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = NumberDigitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  tscf_desc_t                 desc_i,
  input  logic [4*NUMBER_DIGITS-1:0] bcd_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [7:0]                 m_byte_o,
  output logic                       m_last_o
);

  localparam int unsigned PosWidth = $clog2(NUMBER_DIGITS + 4);
  localparam int unsigned DigWidth = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  logic [3:0]          digit [NUMBER_DIGITS];
  logic [NUMBER_DIGITS-1:0] blank;
  logic                lead;
  logic [PosWidth-1:0] step_q, step_d;
  logic [PosWidth-1:0] pos;
  logic [PosWidth-1:0] sfx_pos;
  logic [DigWidth-1:0] dig_idx;
  logic [7:0]          word;
  logic                is_last;
  logic                load;

  logic                valid_q, valid_d;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;

  // Split the number and blank its leading zeros
  always_comb begin
    lead = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      digit[i] = bcd_i[4*i +: 4];
      blank[i] = lead && (digit[i] == 4'd0) && (i != 0);
      if (digit[i] != 4'd0) lead = 1'b0;
    end
  end

  // Position within the entry; skip the prefix when not numbered
  assign pos     = step_q + (desc_i.numbered ? PosWidth'(0) : PosWidth'(NUMBER_DIGITS + 1));
  assign sfx_pos = pos - PosWidth'(NUMBER_DIGITS + 1);
  assign dig_idx = DigWidth'(PosWidth'(NUMBER_DIGITS - 1) - pos);
  assign is_last = (sfx_pos == PosWidth'(desc_i.sfx_last)) &&
                   (pos > PosWidth'(NUMBER_DIGITS));

  // Select the word at this position
  always_comb begin
    if (pos < PosWidth'(NUMBER_DIGITS)) begin
      word = blank[dig_idx] ? CHAR_SPACE : (CHAR_ZERO + {4'd0, digit[dig_idx]});
    end else if (pos == PosWidth'(NUMBER_DIGITS)) begin
      word = CHAR_TAB;
    end else begin
      word = desc_i.sfx[sfx_pos[1:0]];
    end
  end

  assign load  = q_valid_i && (!valid_q || m_ready_i);
  assign pop_o = load && is_last;

  // Load the output stage and step through the entry
  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = word;
      last_d  = is_last;
      step_d  = is_last ? '0 : step_q + 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Hold the word payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign m_valid_o = valid_q;
  assign m_byte_o  = byte_q;
  assign m_last_o  = last_q;

endmodule

// ===== rtl/core/text_stream_cat_filter.sv =====
// ----------------------------------------------------------------------------
// text_stream_cat_filter
// Line numbering and visible-character text filter on byte streams.
// ----------------------------------------------------------------------------
// Takes one text byte per input word and emits its transformed bytes as
// output words, with tlast on the final word caused by each input byte.
// Plain text flows at one byte per cycle while the output accepts words.
// An input byte that expands into k words (a line number prefix of
// NUMBER_DIGITS digits and a tab, a '$' end marker, caret escapes) holds
// the output sequencer until its k words are out; the input side keeps
// taking bytes until the descriptor queue of QUEUE_DEPTH entries fills.
// Squeezed blank lines are taken and emit nothing. Options go through the
// APB port at byte address 4*index; the user must write them only while the
// stream is idle, which the block does not check; reset clears all of them.
// ----------------------------------------------------------------------------
module text_stream_cat_filter import tscf_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = NumberDigitsDefault,
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] in_byte
  // Output stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,   // [7:0] out_byte
  output logic                    m_axis_tlast,   // last_of_run
  // Configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned BcdWidth   = 4 * NUMBER_DIGITS;
  localparam int unsigned EntryWidth = BcdWidth + $bits(tscf_desc_t);

  tscf_cfg_t           cfg_q, cfg_d;
  logic [2:0]          reg_idx;
  logic                cfg_wr;
  logic                rd_bit;

  logic                q_full, q_push, q_pop, q_valid;
  tscf_desc_t          f_desc, b_desc;
  logic [BcdWidth-1:0] f_bcd, b_bcd;
  logic [EntryWidth-1:0] q_rdata;

  // Register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_NUMBER_NONBLANK: cfg_d.number_nonblank = pwdata[0];
        REG_NUMBER_ALL:      cfg_d.number_all      = pwdata[0];
        REG_SQUEEZE_BLANK:   cfg_d.squeeze_blank   = pwdata[0];
        REG_SHOW_ENDS:       cfg_d.show_ends       = pwdata[0];
        REG_SHOW_TABS:       cfg_d.show_tabs       = pwdata[0];
        REG_SHOW_NONPRINT:   cfg_d.show_nonprint   = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUMBER_NONBLANK: rd_bit = cfg_q.number_nonblank;
      REG_NUMBER_ALL:      rd_bit = cfg_q.number_all;
      REG_SQUEEZE_BLANK:   rd_bit = cfg_q.squeeze_blank;
      REG_SHOW_ENDS:       rd_bit = cfg_q.show_ends;
      REG_SHOW_TABS:       rd_bit = cfg_q.show_tabs;
      REG_SHOW_NONPRINT:   rd_bit = cfg_q.show_nonprint;
      default:             rd_bit = 1'b0;
    endcase
  end
  assign prdata = {31'd0, rd_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify
  tscf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_byte_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .desc_o    (f_desc),
    .bcd_o     (f_bcd)
  );

  // Descriptor queue
  tscf_queue #(
    .WIDTH(EntryWidth),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_bcd, f_desc}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign b_bcd  = q_rdata[EntryWidth-1 -: BcdWidth];
  assign b_desc = tscf_desc_t'(q_rdata[$bits(tscf_desc_t)-1:0]);

  // Back: emit output words
  tscf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .desc_i    (b_desc),
    .bcd_i     (b_bcd),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_byte_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule
